@@ design/ordered_list_engine_top_defines.svh @@
// ----------------------------------------------------------------------------
// ordered list engine assertion macros
// shared property wrappers for the controller and datapath checks
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_TOP_DEFINES_SVH
`define ORDERED_LIST_ENGINE_TOP_DEFINES_SVH

// plain invariant, checked at every edge outside reset
`define OLE_CHECK(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// same-cycle implication, checked outside reset
`define OLE_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ design/oleng_pkg.sv @@
// ----------------------------------------------------------------------------
// oleng_pkg
// field widths, action and status codes, and the controller/datapath bundles
// ----------------------------------------------------------------------------
package oleng_pkg;

	localparam int ACT_W  = 3;
	localparam int VAL_W  = 32;
	localparam int POS_W  = 8;
	localparam int STAT_W = 3;

	// action codes
	localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_INS_END   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_INS_POS   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DEL_FIRST = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DEL_LAST  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_DEL_KEY   = 3'd5;
	localparam logic [ACT_W-1:0] ACT_READ      = 3'd6;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOPOS    = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

	typedef logic [2:0] ptr_op_t;
	localparam ptr_op_t PTR_HOLD  = 3'd0;
	localparam ptr_op_t PTR_ZERO  = 3'd1;
	localparam ptr_op_t PTR_COUNT = 3'd2;
	localparam ptr_op_t PTR_INC   = 3'd3;
	localparam ptr_op_t PTR_DEC   = 3'd4;

	typedef logic [1:0] tgt_sel_t;
	localparam tgt_sel_t TGT_FRONT = 2'd0;
	localparam tgt_sel_t TGT_END   = 2'd1;
	localparam tgt_sel_t TGT_POS   = 2'd2;

	typedef logic [1:0] rd_sel_t;
	localparam rd_sel_t RD_PTR    = 2'd0;
	localparam rd_sel_t RD_PTR_M1 = 2'd1;
	localparam rd_sel_t RD_PTR_P1 = 2'd2;

	typedef logic [1:0] cnt_op_t;
	localparam cnt_op_t CNT_HOLD = 2'd0;
	localparam cnt_op_t CNT_INC  = 2'd1;
	localparam cnt_op_t CNT_DEC  = 2'd2;

	localparam logic WR_VALUE = 1'b0;
	localparam logic WR_RDATA = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic              take;
		ptr_op_t           ptr_op;
		tgt_sel_t          tgt_sel;
		logic              mem_rd;
		rd_sel_t           rd_sel;
		logic              mem_wr;
		logic              wr_sel;
		cnt_op_t           cnt_op;
		logic              out_load;
		logic              out_elem;
		logic [STAT_W-1:0] out_status;
		logic              out_last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cnt_zero;
		logic cnt_full;
		logic pos_bad;
		logic ptr_gt_tgt;
		logic ptr_p1_lt_cnt;
		logic ptr_lt_cnt;
		logic ptr_p1_eq_cnt;
		logic key_hit;
		logic out_free;
	} sts_t;

endpackage

@@ design/oleng_ram.sv @@
// ----------------------------------------------------------------------------
// oleng_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module oleng_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/oleng_dp.sv @@
// ----------------------------------------------------------------------------
// oleng_dp
// list storage, element count, walk pointer and the result register
// ----------------------------------------------------------------------------
`include "ordered_list_engine_top_defines.svh"

module oleng_dp #(
	parameter int CAPACITY = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  oleng_pkg::cmd_t                  cmd,
	output oleng_pkg::sts_t                  sts,
	input  logic [oleng_pkg::VAL_W-1:0]      in_value,
	input  logic [oleng_pkg::POS_W-1:0]      in_position,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [oleng_pkg::STAT_W-1:0]     out_status,
	output logic [oleng_pkg::VAL_W-1:0]      out_element,
	output logic                             out_last
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = oleng_pkg::POS_W + 1;

	logic [CW-1:0]                   count_q;
	logic [CW-1:0]                   ptr_q;
	logic [CW-1:0]                   tgt_q;
	logic [oleng_pkg::VAL_W-1:0]     value_q;
	logic [oleng_pkg::POS_W-1:0]     pos_q;
	logic                            out_valid_q;
	logic [oleng_pkg::STAT_W-1:0]    out_status_q;
	logic [oleng_pkg::VAL_W-1:0]     out_element_q;
	logic                            out_last_q;

	logic [CW-1:0]                   ptr_p1;
	logic [CW-1:0]                   ptr_m1;
	logic [CW-1:0]                   rd_ptr;
	logic [CW-1:0]                   tgt_d;
	logic [PW-1:0]                   cnt_p1;
	logic [oleng_pkg::VAL_W-1:0]     rd_data;
	logic [oleng_pkg::VAL_W-1:0]     wr_data;

	assign ptr_p1 = ptr_q + CW'(1);
	assign ptr_m1 = ptr_q - CW'(1);
	assign cnt_p1 = PW'(count_q) + PW'(1);

	always_comb begin
		unique case (cmd.rd_sel)
			oleng_pkg::RD_PTR_M1: rd_ptr = ptr_m1;
			oleng_pkg::RD_PTR_P1: rd_ptr = ptr_p1;
			default:              rd_ptr = ptr_q;
		endcase
	end

	always_comb begin
		unique case (cmd.tgt_sel)
			oleng_pkg::TGT_END: tgt_d = count_q;
			oleng_pkg::TGT_POS: tgt_d = CW'(pos_q - oleng_pkg::POS_W'(1));
			default:            tgt_d = '0;
		endcase
	end

	assign wr_data = (cmd.wr_sel == oleng_pkg::WR_RDATA) ? rd_data : value_q;

	oleng_ram #(
		.WIDTH(oleng_pkg::VAL_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (cmd.mem_wr),
		.waddr(ptr_q[AW-1:0]),
		.wdata(wr_data),
		.re   (cmd.mem_rd),
		.raddr(rd_ptr[AW-1:0]),
		.rdata(rd_data)
	);

	// count, pointer, target and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			tgt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.cnt_op)
				oleng_pkg::CNT_INC: count_q <= count_q + CW'(1);
				oleng_pkg::CNT_DEC: count_q <= count_q - CW'(1);
				default:            count_q <= count_q;
			endcase
			unique case (cmd.ptr_op)
				oleng_pkg::PTR_ZERO:  ptr_q <= '0;
				oleng_pkg::PTR_COUNT: ptr_q <= count_q;
				oleng_pkg::PTR_INC:   ptr_q <= ptr_p1;
				oleng_pkg::PTR_DEC:   ptr_q <= ptr_m1;
				default:              ptr_q <= ptr_q;
			endcase
			if (cmd.ptr_op == oleng_pkg::PTR_COUNT) begin
				tgt_q <= tgt_d;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			value_q <= in_value;
			pos_q   <= in_position;
		end
		if (cmd.out_load) begin
			out_status_q  <= cmd.out_status;
			out_element_q <= cmd.out_elem ? rd_data : '0;
			out_last_q    <= cmd.out_last;
		end
	end

	always_comb begin
		sts.cnt_zero      = (count_q == '0);
		sts.cnt_full      = (count_q == CW'(CAPACITY));
		sts.pos_bad       = (pos_q == '0) || (PW'(pos_q) > cnt_p1);
		sts.ptr_gt_tgt    = (ptr_q > tgt_q);
		sts.ptr_p1_lt_cnt = (ptr_p1 < count_q);
		sts.ptr_lt_cnt    = (ptr_q < count_q);
		sts.ptr_p1_eq_cnt = (ptr_p1 == count_q);
		sts.key_hit       = (rd_data == value_q);
		sts.out_free      = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_element = out_element_q;
	assign out_last    = out_last_q;

	`OLE_CHECK(a_cnt_cap, count_q <= CW'(CAPACITY), "element count above capacity")
	`OLE_IMPLY(a_wr_in_list, cmd.mem_wr, ptr_q <= count_q, "write beyond list end")

endmodule

@@ design/oleng_ctrl.sv @@
// ----------------------------------------------------------------------------
// oleng_ctrl
// sequencer that steps each action through shifts, scans and result emits
// ----------------------------------------------------------------------------
`include "ordered_list_engine_top_defines.svh"

module oleng_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [oleng_pkg::ACT_W-1:0]   in_action,
	input  oleng_pkg::sts_t               sts,
	output oleng_pkg::cmd_t               cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECODE   = 4'd1;
	localparam logic [3:0] S_INS_RD   = 4'd2;
	localparam logic [3:0] S_INS_WR   = 4'd3;
	localparam logic [3:0] S_DEL_RD   = 4'd4;
	localparam logic [3:0] S_DEL_WR   = 4'd5;
	localparam logic [3:0] S_SCAN_RD  = 4'd6;
	localparam logic [3:0] S_SCAN_CMP = 4'd7;
	localparam logic [3:0] S_OUT_RD   = 4'd8;
	localparam logic [3:0] S_OUT_EMIT = 4'd9;
	localparam logic [3:0] S_EMIT     = 4'd10;

	logic [3:0]                       state_q, state_d;
	logic [oleng_pkg::ACT_W-1:0]      act_q;
	logic [oleng_pkg::STAT_W-1:0]     st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q   <= oleng_pkg::ACT_INS_FRONT;
			st_q    <= oleng_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			if (cmd.take) begin
				act_q <= in_action;
			end
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d        = state_q;
		st_d           = st_q;
		cmd            = '0;
		cmd.ptr_op     = oleng_pkg::PTR_HOLD;
		cmd.cnt_op     = oleng_pkg::CNT_HOLD;
		cmd.out_status = oleng_pkg::ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (act_q) inside
					oleng_pkg::ACT_INS_FRONT, oleng_pkg::ACT_INS_END,
					oleng_pkg::ACT_INS_POS: begin
						if (sts.cnt_full) begin
							st_d    = oleng_pkg::ST_FULL;
							state_d = S_EMIT;
						end else if (act_q == oleng_pkg::ACT_INS_POS && sts.pos_bad) begin
							st_d    = oleng_pkg::ST_NOPOS;
							state_d = S_EMIT;
						end else begin
							cmd.ptr_op = oleng_pkg::PTR_COUNT;
							if (act_q == oleng_pkg::ACT_INS_FRONT) begin
								cmd.tgt_sel = oleng_pkg::TGT_FRONT;
							end else if (act_q == oleng_pkg::ACT_INS_END) begin
								cmd.tgt_sel = oleng_pkg::TGT_END;
							end else begin
								cmd.tgt_sel = oleng_pkg::TGT_POS;
							end
							state_d = S_INS_RD;
						end
					end
					oleng_pkg::ACT_DEL_FIRST: begin
						if (sts.cnt_zero) begin
							st_d    = oleng_pkg::ST_EMPTY;
							state_d = S_EMIT;
						end else begin
							cmd.ptr_op = oleng_pkg::PTR_ZERO;
							state_d    = S_DEL_RD;
						end
					end
					oleng_pkg::ACT_DEL_LAST: begin
						if (sts.cnt_zero) begin
							st_d = oleng_pkg::ST_EMPTY;
						end else begin
							st_d       = oleng_pkg::ST_OK;
							cmd.cnt_op = oleng_pkg::CNT_DEC;
						end
						state_d = S_EMIT;
					end
					oleng_pkg::ACT_DEL_KEY: begin
						cmd.ptr_op = oleng_pkg::PTR_ZERO;
						state_d    = S_SCAN_RD;
					end
					oleng_pkg::ACT_READ: begin
						if (sts.cnt_zero) begin
							st_d    = oleng_pkg::ST_EMPTY;
							state_d = S_EMIT;
						end else begin
							cmd.ptr_op = oleng_pkg::PTR_ZERO;
							state_d    = S_OUT_RD;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_INS_RD: begin
				if (sts.ptr_gt_tgt) begin
					cmd.mem_rd = 1'b1;
					cmd.rd_sel = oleng_pkg::RD_PTR_M1;
					state_d    = S_INS_WR;
				end else begin
					// pointer now sits on the insert slot
					cmd.mem_wr = 1'b1;
					cmd.wr_sel = oleng_pkg::WR_VALUE;
					cmd.cnt_op = oleng_pkg::CNT_INC;
					st_d       = oleng_pkg::ST_OK;
					state_d    = S_EMIT;
				end
			end
			S_INS_WR: begin
				cmd.mem_wr = 1'b1;
				cmd.wr_sel = oleng_pkg::WR_RDATA;
				cmd.ptr_op = oleng_pkg::PTR_DEC;
				state_d    = S_INS_RD;
			end
			S_DEL_RD: begin
				if (sts.ptr_p1_lt_cnt) begin
					cmd.mem_rd = 1'b1;
					cmd.rd_sel = oleng_pkg::RD_PTR_P1;
					state_d    = S_DEL_WR;
				end else begin
					cmd.cnt_op = oleng_pkg::CNT_DEC;
					st_d       = oleng_pkg::ST_OK;
					state_d    = S_EMIT;
				end
			end
			S_DEL_WR: begin
				cmd.mem_wr = 1'b1;
				cmd.wr_sel = oleng_pkg::WR_RDATA;
				cmd.ptr_op = oleng_pkg::PTR_INC;
				state_d    = S_DEL_RD;
			end
			S_SCAN_RD: begin
				if (sts.ptr_lt_cnt) begin
					cmd.mem_rd = 1'b1;
					cmd.rd_sel = oleng_pkg::RD_PTR;
					state_d    = S_SCAN_CMP;
				end else begin
					st_d    = oleng_pkg::ST_NOTFOUND;
					state_d = S_EMIT;
				end
			end
			S_SCAN_CMP: begin
				if (sts.key_hit) begin
					state_d = S_DEL_RD;
				end else begin
					cmd.ptr_op = oleng_pkg::PTR_INC;
					state_d    = S_SCAN_RD;
				end
			end
			S_OUT_RD: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_sel = oleng_pkg::RD_PTR;
				state_d    = S_OUT_EMIT;
			end
			S_OUT_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_elem   = 1'b1;
					cmd.out_status = oleng_pkg::ST_OK;
					cmd.out_last   = sts.ptr_p1_eq_cnt;
					cmd.ptr_op     = oleng_pkg::PTR_INC;
					state_d        = sts.ptr_p1_eq_cnt ? S_IDLE : S_OUT_RD;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = st_q;
					cmd.out_last   = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`OLE_IMPLY(a_load_when_free, cmd.out_load, sts.out_free, "result load over a pending word")
	`OLE_CHECK(a_rd_wr_excl, !(cmd.mem_rd && cmd.mem_wr), "ram read and write in one cycle")
	`OLE_IMPLY(a_no_grow_full, cmd.cnt_op == oleng_pkg::CNT_INC, !sts.cnt_full, "insert into full list")

endmodule

@@ design/ordered_list_engine_top.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// ordered list of signed 32-bit values with insert, delete and readout
//
//   channel   | direction | tdata                          | tuser        | tlast
//   ----------+-----------+--------------------------------+--------------+------------
//   s_axis    | in        | [31:0] value, [39:32] position | [2:0] action | none
//   m_axis    | out       | [31:0] element                 | [2:0] status | last of run
//
// insert shifts each element past the slot one place toward the end, then
// writes the value; delete key scans for the key, and it and delete first
// then shift each later element one place toward the front; delete last,
// rejected actions and an empty readout emit one status word; readout emits
// one word per element; the unused code emits nothing. the single ram port
// pair (one read, one write) sets the shift and scan rate.
// reset clears the element count, the sequencer and the result valid flag;
// stored elements need no clearing since only the first count are read.
// a stalled result word holds the sequencer only when it has a new word to
// load; one pending word waits in the result register.
// ----------------------------------------------------------------------------
module ordered_list_engine_top #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	// input words
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [31:0] value, [39:32] position
	input  logic [2:0]  s_axis_tuser,   // [2:0] action

	// result words
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] element
	output logic [2:0]  m_axis_tuser,   // [2:0] status
	output logic        m_axis_tlast    // last result word of an action
);

	oleng_pkg::cmd_t cmd;
	oleng_pkg::sts_t sts;

	// sequencer: one action at a time, ready only when idle
	oleng_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_action(s_axis_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage, walk pointer and result register
	oleng_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_value   (s_axis_tdata[31:0]),
		.in_position(s_axis_tdata[39:32]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_element(m_axis_tdata),
		.out_last   (m_axis_tlast)
	);

endmodule
